// ----- hw/rtl/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants of the line pattern match counter
// Field widths, register indexes, result kinds, the queued result record and
// the pattern byte selector used by the matcher.
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam logic [7:0] NL_BYTE = 8'h0A;

    // Pattern bytes held by the two 64-bit pattern registers.
    localparam int PAT_BYTES = 16;

    localparam int LINE_W  = 32;
    localparam int COUNT_W = 32;
    localparam int TOTAL_W = 16;
    localparam int PLEN_W  = 5;

    localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Configuration port: 64-bit data, registers at byte address 8*i.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } reg_index_t;

    typedef enum logic {
        EVENT_MATCH   = 1'b0,
        EVENT_SUMMARY = 1'b1
    } event_kind_t;

    // Result queue depth, in records (one per result-producing transaction).
    localparam int QUEUE_DEPTH = 2;

    // Everything one input transaction produces: an optional match result
    // and an optional file summary, sharing the file match count.
    typedef struct packed {
        logic               has_match;
        logic               has_summary;
        logic [LINE_W-1:0]  line;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] searched;
        logic [TOTAL_W-1:0] matched;
    } rec_t;

    function automatic logic [7:0] pattern_byte(input logic [63:0] low_bytes,
                                                input logic [63:0] high_bytes,
                                                input logic [3:0]  idx);
        logic [63:0] word;
        word = idx[3] ? high_bytes : low_bytes;
        return word[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ----- hw/rtl/lpm_if.sv -----
// ----------------------------------------------------------------------------
// lpm_if: stream channels of the line pattern match counter
// Input channel carries text bytes, output channel carries result records.
// ----------------------------------------------------------------------------
interface lpm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       file_end;

    modport source (output valid, output text_byte, output file_end, input ready);
    modport sink   (input valid, input text_byte, input file_end, output ready);
endinterface

interface lpm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        event_kind;
    logic [lpm_pkg::LINE_W-1:0]  line_number;
    logic [lpm_pkg::COUNT_W-1:0] file_match_count;
    logic [lpm_pkg::TOTAL_W-1:0] files_searched_total;
    logic [lpm_pkg::TOTAL_W-1:0] files_matched_total;
    logic                        last_of_run;

    modport source (output valid, output event_kind, output line_number,
                    output file_match_count, output files_searched_total,
                    output files_matched_total, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input line_number,
                    input file_match_count, input files_searched_total,
                    input files_matched_total, input last_of_run, output ready);
endinterface

// ----- hw/rtl/lpm_cell.sv -----
// ----------------------------------------------------------------------------
// lpm_cell: one window position of the match chain
// Holds one text byte and a flag that the byte belongs to the current line,
// passes both to the next cell on every shift, and compares the incoming
// byte against its aligned pattern byte.
// ----------------------------------------------------------------------------
module lpm_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic       clear,
    input  logic [7:0] in_byte,
    input  logic       in_valid,
    input  logic       enable,
    input  logic [7:0] pat_byte,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       hit
);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       valid_reg;
    logic       valid_next;

    always_comb
    begin
        data_next = shift ? in_byte : data_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = in_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The compare looks at the byte that this cell takes on the shift.
    assign hit       = !enable || (in_valid && (in_byte == pat_byte));
    assign out_byte  = data_reg;
    assign out_valid = valid_reg;

endmodule

// ----- hw/rtl/lpm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lpm_cfg_regs: configuration registers
// APB-style write and read of pattern length and the sixteen pattern bytes.
// ----------------------------------------------------------------------------
module lpm_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lpm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lpm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [lpm_pkg::PLEN_W-1:0]         pattern_length,
    output logic [63:0]                        pattern_low_bytes,
    output logic [63:0]                        pattern_high_bytes
);

    logic [lpm_pkg::PLEN_W-1:0] plen_reg;
    logic [lpm_pkg::PLEN_W-1:0] plen_next;
    logic [63:0]                low_reg;
    logic [63:0]                low_next;
    logic [63:0]                high_reg;
    logic [63:0]                high_next;
    logic                       wr_en;
    logic [1:0]                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[lpm_pkg::CFG_ADDR_W-1:3];

    always_comb
    begin
        plen_next = plen_reg;
        low_next  = low_reg;
        high_next = high_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                lpm_pkg::REG_PATTERN_LENGTH: plen_next = pwdata[lpm_pkg::PLEN_W-1:0];
                lpm_pkg::REG_PATTERN_LOW:    low_next  = pwdata;
                lpm_pkg::REG_PATTERN_HIGH:   high_next = pwdata;
                default:                     plen_next = plen_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lpm_pkg::REG_PATTERN_LENGTH: prdata = {{(lpm_pkg::CFG_DATA_W-lpm_pkg::PLEN_W){1'b0}},
                                                   plen_reg};
            lpm_pkg::REG_PATTERN_LOW:    prdata = low_reg;
            lpm_pkg::REG_PATTERN_HIGH:   prdata = high_reg;
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= lpm_pkg::PLEN_W'(1);
            low_reg  <= '0;
            high_reg <= '0;
        end
        else
        begin
            plen_reg <= plen_next;
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign pattern_length     = plen_reg;
    assign pattern_low_bytes  = low_reg;
    assign pattern_high_bytes = high_reg;

endmodule

// ----- hw/rtl/lpm_result_queue.sv -----
// ----------------------------------------------------------------------------
// lpm_result_queue: result record queue and output sequencer
// Stores one record per producing input transaction and unpacks it into a
// match result and/or a file summary on the output channel.
// ----------------------------------------------------------------------------
module lpm_result_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lpm_pkg::rec_t   push_rec,
    output logic            space,
    lpm_out_if.source       out_item
);

    localparam int PTR_W = (lpm_pkg::QUEUE_DEPTH > 1) ? $clog2(lpm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lpm_pkg::QUEUE_DEPTH + 1);

    lpm_pkg::rec_t    store_reg [lpm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             phase_reg;
    logic             phase_next;
    lpm_pkg::rec_t    head;
    logic             first_is_match;
    logic             take;
    logic             pop;

    assign head           = store_reg[rd_ptr_reg];
    assign space          = (count_reg != CNT_W'(lpm_pkg::QUEUE_DEPTH));
    assign first_is_match = head.has_match && !phase_reg;

    // Output fields follow from the head record and the phase flag.
    always_comb
    begin
        out_item.valid            = (count_reg != '0);
        out_item.file_match_count = head.count;
        if (first_is_match)
        begin
            out_item.event_kind           = lpm_pkg::EVENT_MATCH;
            out_item.line_number          = head.line;
            out_item.files_searched_total = '0;
            out_item.files_matched_total  = '0;
            out_item.last_of_run          = !head.has_summary;
        end
        else
        begin
            out_item.event_kind           = lpm_pkg::EVENT_SUMMARY;
            out_item.line_number          = '0;
            out_item.files_searched_total = head.searched;
            out_item.files_matched_total  = head.matched;
            out_item.last_of_run          = 1'b1;
        end
    end

    assign take = out_item.valid && out_item.ready;
    assign pop  = take && out_item.last_of_run;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lpm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lpm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            phase_next  = 1'b0;
        end
        else if (take)
        begin
            phase_next = 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
        end
    end

    // A record is only written when a slot is free.
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("record written into a full result queue");

    // The second half of a record is only pending for a record that has both.
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (count_reg != '0) && head.has_match && head.has_summary)
        else $error("summary phase set without a two-result record at the head");

    // Every stored record yields at least one result.
    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> (head.has_match || head.has_summary))
        else $error("empty record at the head of the result queue");

endmodule

// ----- hw/rtl/line_pattern_match_counter.sv -----
// ----------------------------------------------------------------------------
// line_pattern_match_counter: overlapping pattern search over text files
// Counts every occurrence of a 1 to 16 byte pattern within lines of a byte
// stream and reports match line numbers and per-file summaries.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Payload                                   Handshake
//  ---------  ---------  ----------------------------------------  ---------------
//  in_item    input      text_byte, file_end                       valid / ready
//  out_item   output     event_kind, line_number, file_match_count, valid / ready
//                        files_searched_total, files_matched_total,
//                        last_of_run
//  APB        input      pattern_length, pattern_low/high_bytes    psel / penable
//
// One input transaction is accepted per cycle while the result queue has
// space. Each produces zero, one or two results; the output channel moves
// one result per cycle while out_item.ready is high, so a byte that both
// completes a match and ends a file yields a match result, then a summary.
// A two-entry result queue separates input from output: input stalls only
// when both entries are taken. Reset is asynchronous and clears the line
// state, counters, queue and configuration; no clearing pass is needed.
//
module line_pattern_match_counter #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    lpm_in_if.sink                             in_item,
    lpm_out_if.source                          out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lpm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lpm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    // Width wide enough for both the length register and PATTERN_MAX.
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CW    = (LEN_W > lpm_pkg::PLEN_W) ? LEN_W : lpm_pkg::PLEN_W;

    logic [lpm_pkg::PLEN_W-1:0] pattern_length;
    logic [63:0]                pattern_low_bytes;
    logic [63:0]                pattern_high_bytes;

    lpm_cfg_regs u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .pattern_length     (pattern_length),
        .pattern_low_bytes  (pattern_low_bytes),
        .pattern_high_bytes (pattern_high_bytes)
    );

    // ------------------------------------------------------------------
    // Input handshake and line control
    // ------------------------------------------------------------------
    logic accept;
    logic is_newline;
    logic shift;
    logic clear;
    logic queue_space;

    assign in_item.ready = queue_space;
    assign accept        = in_item.valid && in_item.ready;
    assign is_newline    = (in_item.text_byte == lpm_pkg::NL_BYTE);
    // A newline ends the line without entering the window; the end of a file
    // also discards the line once this byte has been compared.
    assign shift         = accept && !is_newline;
    assign clear         = accept && (is_newline || in_item.file_end);

    // ------------------------------------------------------------------
    // Match chain: cell k holds the k-th newest byte of the current line.
    // Pattern byte len-1-k lines up with cell k.
    // ------------------------------------------------------------------
    logic [CW-1:0]          len_ext;
    logic [CW-1:0]          len_eff;
    logic [7:0]             win_byte  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] win_valid;
    logic [PATTERN_MAX-1:0] cell_hit;
    logic [PATTERN_MAX-1:0] cell_en;
    logic                   match;

    assign len_ext = CW'(pattern_length);
    // A length above the window size is treated as the window size.
    assign len_eff = (len_ext > CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : len_ext;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        localparam logic [CW-1:0] POS = CW'(k);

        logic [CW-1:0] pat_idx;
        logic [7:0]    pat_byte;
        logic [7:0]    in_byte;
        logic          in_valid;

        assign cell_en[k] = (len_eff > POS);
        assign pat_idx    = len_eff - POS - CW'(1);
        // Positions past the sixteen configured bytes compare against zero.
        assign pat_byte   = (pat_idx < CW'(lpm_pkg::PAT_BYTES))
                          ? lpm_pkg::pattern_byte(pattern_low_bytes, pattern_high_bytes,
                                                  pat_idx[3:0])
                          : 8'h00;

        if (k == 0)
        begin : g_head
            assign in_byte  = in_item.text_byte;
            assign in_valid = 1'b1;
        end
        else
        begin : g_link
            assign in_byte  = win_byte[k-1];
            assign in_valid = win_valid[k-1];
        end

        lpm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .clear     (clear),
            .in_byte   (in_byte),
            .in_valid  (in_valid),
            .enable    (cell_en[k]),
            .pat_byte  (pat_byte),
            .out_byte  (win_byte[k]),
            .out_valid (win_valid[k]),
            .hit       (cell_hit[k])
        );
    end

    // A zero length enables no cell and must never count as a match.
    assign match = !is_newline && (len_eff != '0) && (&cell_hit);

    // ------------------------------------------------------------------
    // Line and file counters, all saturating
    // ------------------------------------------------------------------
    logic [lpm_pkg::LINE_W-1:0]  line_reg;
    logic [lpm_pkg::LINE_W-1:0]  line_next;
    logic [lpm_pkg::COUNT_W-1:0] match_count_reg;
    logic [lpm_pkg::COUNT_W-1:0] match_count_next;
    logic [lpm_pkg::COUNT_W-1:0] count_now;
    logic [lpm_pkg::TOTAL_W-1:0] searched_reg;
    logic [lpm_pkg::TOTAL_W-1:0] searched_next;
    logic [lpm_pkg::TOTAL_W-1:0] searched_now;
    logic [lpm_pkg::TOTAL_W-1:0] matched_reg;
    logic [lpm_pkg::TOTAL_W-1:0] matched_next;
    logic [lpm_pkg::TOTAL_W-1:0] matched_now;
    lpm_pkg::rec_t               rec;
    logic                        push;

    // Count as it stands after this byte; the summary of this byte uses it.
    assign count_now    = (match && (match_count_reg != lpm_pkg::COUNT_MAX))
                        ? match_count_reg + 1'b1 : match_count_reg;
    assign searched_now = (searched_reg != lpm_pkg::TOTAL_MAX)
                        ? searched_reg + 1'b1 : searched_reg;
    assign matched_now  = ((count_now != '0) && (matched_reg != lpm_pkg::TOTAL_MAX))
                        ? matched_reg + 1'b1 : matched_reg;

    always_comb
    begin
        line_next        = line_reg;
        match_count_next = match_count_reg;
        searched_next    = searched_reg;
        matched_next     = matched_reg;
        if (accept)
        begin
            if (in_item.file_end)
            begin
                line_next        = lpm_pkg::LINE_W'(1);
                match_count_next = '0;
                searched_next    = searched_now;
                matched_next     = matched_now;
            end
            else
            begin
                match_count_next = count_now;
                if (is_newline && (line_reg != lpm_pkg::LINE_MAX))
                begin
                    line_next = line_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg        <= lpm_pkg::LINE_W'(1);
            match_count_reg <= '0;
            searched_reg    <= '0;
            matched_reg     <= '0;
        end
        else
        begin
            line_reg        <= line_next;
            match_count_reg <= match_count_next;
            searched_reg    <= searched_next;
            matched_reg     <= matched_next;
        end
    end

    // ------------------------------------------------------------------
    // Result record for this transaction
    // ------------------------------------------------------------------
    always_comb
    begin
        rec.has_match   = match;
        rec.has_summary = in_item.file_end;
        rec.line        = line_reg;
        rec.count       = count_now;
        rec.searched    = searched_now;
        rec.matched     = matched_now;
    end

    assign push = accept && (match || in_item.file_end);

    lpm_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (rec),
        .space    (queue_space),
        .out_item (out_item)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Line numbers start at one and never wrap to zero.
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line number reached zero");

    // Cells fill from the head: a cell can only hold a line byte if its
    // newer neighbor does too.
    for (genvar m = 1; m < PATTERN_MAX; m++)
    begin : g_chk
        a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
            win_valid[m] |-> win_valid[m-1])
            else $error("window fill order broken in the cell chain");
    end

    // A file summary always closes the results of its transaction.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && (out_item.event_kind == lpm_pkg::EVENT_SUMMARY))
            |-> out_item.last_of_run)
        else $error("file summary not marked as final result");

    // After the end of a file the chain holds no line bytes.
    a_file_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.file_end) |=> (win_valid == '0) && (match_count_reg == '0))
        else $error("line state survived the end of a file");

endmodule
